// ===== sv/smu_pkg.sv =====
// Shared types, constants and helpers for the SGD momentum update engine.
// Used by smu_front, smu_div, smu_back and sgd_momentum_update.
package smu_pkg;

  localparam int unsigned ELEM_COUNT_DEF  = 65536;
  localparam int unsigned GROUP_COUNT_DEF = 16;

  localparam logic [16:0] Q_ONE    = 17'd65536;
  localparam logic [30:0] LR_RESET = 31'd655;

  // Request type codes
  localparam logic [1:0] REQ_NORM     = 2'd0;
  localparam logic [1:0] REQ_UPDATE   = 2'd1;
  localparam logic [1:0] REQ_OVERRIDE = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_LR    = 2'd0;
  localparam logic [1:0] REG_MOM   = 2'd1;
  localparam logic [1:0] REG_DECAY = 2'd2;
  localparam logic [1:0] REG_CLIP  = 2'd3;

  // Override kinds
  localparam logic KIND_RATE  = 1'b0;
  localparam logic KIND_DECAY = 1'b1;

  localparam int unsigned DIV_DW = 47;
  localparam int unsigned DIV_SW = 32;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_NORM,
    OP_UPDATE,
    OP_OVERRIDE
  } op_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [15:0]        elem_index;
    logic [3:0]         group_index;
    logic signed [31:0] weight_in;
    logic signed [31:0] grad_in;
    logic               norm_last;
    logic               override_kind;
    logic [30:0]        override_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] weight_out;
    logic signed [31:0] velocity_out;
    logic [16:0]        clip_scale;
    logic               saturated;
  } rsp_t;

  typedef struct packed {
    op_e                op;
    logic               grp_ok;
    logic [15:0]        elem_index;
    logic [3:0]         group_index;
    logic signed [31:0] weight_in;
    logic signed [31:0] grad_in;
    logic               norm_last;
    logic               override_kind;
    logic [30:0]        override_value;
  } op_t;

  typedef struct packed {
    logic [30:0] lr;
    logic [30:0] mom;
    logic [30:0] decay;
    logic [30:0] clip;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_SW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_DW-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

  localparam logic signed [51:0] MAX32 = 52'sd2147483647;
  localparam logic signed [51:0] MIN32 = -52'sd2147483648;

  // Clamp to signed 32 bits; bit 32 flags a clamp
  function automatic logic [32:0] sat32(input logic signed [51:0] x);
    logic [32:0] r;
    if (x > MAX32) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (x < MIN32) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, x[31:0]};
    end
    return r;
  endfunction

endpackage

// ===== sv/smu_front.sv =====
// Front end: accepts request beats, classifies them and queues them.
// Depends on smu_pkg; feeds smu_back through a two-entry queue.
module smu_front import smu_pkg::*; #(
  parameter int unsigned GROUP_COUNT = GROUP_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  req_t       in_data_i,
  output logic       q_valid_o,
  output op_t        q_op_o,
  input  back_stat_t stat_i
);

  op_t        ent_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       accept, grp_ok;
  op_t        op_in;

  assign in_stall_o = (cnt_q == 2'd2) || stat_i.clearing;
  assign accept     = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_op_o     = ent_q[rd_q];

  // Classify the incoming beat
  always_comb begin
    grp_ok = (32'(in_data_i.group_index) < GROUP_COUNT);
    op_in.grp_ok         = grp_ok;
    op_in.elem_index     = in_data_i.elem_index;
    op_in.group_index    = in_data_i.group_index;
    op_in.weight_in      = in_data_i.weight_in;
    op_in.grad_in        = in_data_i.grad_in;
    op_in.norm_last      = in_data_i.norm_last;
    op_in.override_kind  = in_data_i.override_kind;
    op_in.override_value = in_data_i.override_value;
    unique case (in_data_i.req_type)
      REQ_NORM:     op_in.op = OP_NORM;
      REQ_UPDATE:   op_in.op = OP_UPDATE;
      REQ_OVERRIDE: op_in.op = grp_ok ? OP_OVERRIDE : OP_NONE;
      default:      op_in.op = OP_NONE;
    endcase
  end

  // Advance queue pointers
  always_comb begin
    wr_d  = accept ? !wr_q : wr_q;
    rd_d  = stat_i.pop ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(accept) - 2'(stat_i.pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Hold queued payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ent_q[wr_q] <= op_in;
    end
  end

endmodule

// ===== sv/smu_div.sv =====
// Restoring divider, one quotient bit per cycle; done is flagged once the last bit is in.
// Depends on smu_pkg; computes the clip scale quotient.
module smu_div import smu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, busy_d, done_q, done_d;
  logic [5:0]        cnt_q, cnt_d;
  logic [DIV_DW-1:0] dvd_q, dvd_d;
  logic [DIV_SW-1:0] rem_q, rem_d, dsr_q, dsr_d;
  logic [DIV_SW:0]   shifted;
  logic              ge;

  // Shift in one dividend bit and try the subtract
  always_comb begin
    shifted = {rem_q, dvd_q[DIV_DW-1]};
    ge      = (shifted >= {1'b0, dsr_q});
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? DIV_SW'(shifted - {1'b0, dsr_q}) : DIV_SW'(shifted);
      dvd_d = {dvd_q[DIV_DW-2:0], ge};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(DIV_DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

// ===== sv/smu_back.sv =====
// Back end: executes queued operations with one shared multiplier,
// an iterative square root, the velocity memory and the group tables.
// Depends on smu_pkg and smu_div.
module smu_back import smu_pkg::*; #(
  parameter int unsigned ELEM_COUNT  = ELEM_COUNT_DEF,
  parameter int unsigned GROUP_COUNT = GROUP_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       q_valid_i,
  input  op_t        q_op_i,
  output back_stat_t stat_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output rsp_t       out_data_o
);

  localparam int unsigned AW = (ELEM_COUNT > 1) ? $clog2(ELEM_COUNT) : 1;
  localparam int unsigned GW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
  localparam bit MOD_NEEDED = (ELEM_COUNT < 65536) &&
                              ((ELEM_COUNT & (ELEM_COUNT - 1)) != 0);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_MOD   = 4'd2;
  localparam logic [3:0] ST_U0    = 4'd3;
  localparam logic [3:0] ST_U1    = 4'd4;
  localparam logic [3:0] ST_U2    = 4'd5;
  localparam logic [3:0] ST_U3    = 4'd6;
  localparam logic [3:0] ST_U4    = 4'd7;
  localparam logic [3:0] ST_U5    = 4'd8;
  localparam logic [3:0] ST_N0    = 4'd9;
  localparam logic [3:0] ST_N1    = 4'd10;
  localparam logic [3:0] ST_SQRT  = 4'd11;
  localparam logic [3:0] ST_CMP   = 4'd12;
  localparam logic [3:0] ST_DIV   = 4'd13;
  localparam logic [3:0] ST_OUT   = 4'd14;

  logic [3:0]         state_q, state_d;
  op_t                op_q, op_d;
  logic [AW-1:0]      addr_q, addr_d, clr_q, clr_d;
  logic [30:0]        rate_q, rate_d, decay_q, decay_d;
  logic signed [49:0] acc_q, acc_d;
  logic signed [31:0] g_q, g_d, term_q, term_d, wout_q, wout_d, vout_q, vout_d;
  logic               flag_q, flag_d;
  logic [63:0]        sum_q, sum_d, rn_q, rn_d, root_q, root_d;
  logic [16:0]        scale_q, scale_d;
  logic [4:0]         k_q, k_d;
  logic               out_valid_q, out_valid_d;
  rsp_t               out_q, out_d;

  logic [30:0] gr_q [GROUP_COUNT];
  logic [30:0] gd_q [GROUP_COUNT];
  logic [GROUP_COUNT-1:0] rset_q, rset_d, dset_q, dset_d;
  logic [30:0] rsnap_q, rsnap_d, dsnap_q, dsnap_d;
  logic        ron_q, ron_d, don_q, don_d;

  logic [31:0] vmem [ELEM_COUNT];
  logic [31:0] vrd_q;
  logic        mem_we, mem_re;
  logic [AW-1:0] mem_waddr;
  logic [31:0] mem_wdata;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q;
  logic signed [49:0] psh;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic          pop, tbl_we, out_free;
  logic [GW-1:0] gidx, qidx;
  logic [32:0]   sat_r;
  logic [64:0]   tot;
  logic [63:0]   nsum, bitv, tsum, mrem, mstep;

  smu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign pop      = (state_q == ST_IDLE) && q_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign qidx     = GW'(q_op_i.group_index);
  assign gidx     = GW'(op_q.group_index);
  assign psh      = prod_q[65:16];

  assign stat_o.pop      = pop;
  assign stat_o.clearing = (state_q == ST_CLEAR);
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

  // Select multiplier operands for the step in flight
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_U0: begin
        mul_a = 33'(op_q.grad_in);
        mul_b = {16'b0, scale_q};
      end
      ST_U1: begin
        mul_a = {2'b0, decay_q};
        mul_b = 33'(op_q.weight_in);
      end
      ST_U2: begin
        mul_a = {2'b0, cfg_i.mom};
        mul_b = 33'(signed'(vrd_q));
      end
      ST_U4: begin
        mul_a = {2'b0, rate_q};
        mul_b = 33'(term_q);
      end
      ST_N0: begin
        mul_a = 33'(op_q.grad_in);
        mul_b = 33'(op_q.grad_in);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 66'(mul_a) * 66'(mul_b);
  end

  // Sequence one operation at a time
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    addr_d      = addr_q;
    clr_d       = clr_q;
    rate_d      = rate_q;
    decay_d     = decay_q;
    acc_d       = acc_q;
    g_d         = g_q;
    term_d      = term_q;
    wout_d      = wout_q;
    vout_d      = vout_q;
    flag_d      = flag_q;
    sum_d       = sum_q;
    rn_d        = rn_q;
    root_d      = root_q;
    scale_d     = scale_q;
    k_d         = k_q;
    rset_d      = rset_q;
    dset_d      = dset_q;
    rsnap_d     = rsnap_q;
    dsnap_d     = dsnap_q;
    ron_d       = ron_q;
    don_d       = don_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    tbl_we      = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = '0;
    div_req     = '0;
    sat_r       = '0;
    tot         = '0;
    nsum        = '0;
    mrem        = '0;
    mstep       = '0;
    bitv        = 64'd1 << {k_q, 1'b0};
    tsum        = root_q + bitv;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(ELEM_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop) begin
          op_d   = q_op_i;
          wout_d = '0;
          vout_d = '0;
          flag_d = 1'b0;
          rate_d = (q_op_i.grp_ok && ron_q) ?
                   (rset_q[qidx] ? gr_q[qidx] : rsnap_q) : cfg_i.lr;
          decay_d = (q_op_i.grp_ok && don_q) ?
                    (dset_q[qidx] ? gd_q[qidx] : dsnap_q) : cfg_i.decay;
          addr_d = AW'(q_op_i.elem_index);
          unique case (q_op_i.op)
            OP_NORM: state_d = ST_N0;
            OP_UPDATE: begin
              if (MOD_NEEDED) begin
                rn_d    = 64'(q_op_i.elem_index);
                k_d     = 5'd16;
                state_d = ST_MOD;
              end else begin
                state_d = ST_U0;
              end
            end
            OP_OVERRIDE: begin
              tbl_we = 1'b1;
              if (q_op_i.override_kind == KIND_RATE) begin
                if (!ron_q) begin
                  ron_d   = 1'b1;
                  rsnap_d = cfg_i.lr;
                end
                rset_d[qidx] = 1'b1;
              end else begin
                if (!don_q) begin
                  don_d   = 1'b1;
                  dsnap_d = cfg_i.decay;
                end
                dset_d[qidx] = 1'b1;
              end
              state_d = ST_OUT;
            end
            default: state_d = ST_OUT;
          endcase
        end
      end
      // Wrap the address: four compare-and-subtract steps per cycle
      ST_MOD: begin
        mrem = rn_q;
        for (int s = 1; s <= 4; s++) begin
          mstep = 64'(ELEM_COUNT) << (k_q - 5'(s));
          if (mrem >= mstep) begin
            mrem = mrem - mstep;
          end
        end
        rn_d = mrem;
        k_d  = k_q - 5'd4;
        if (k_q == 5'd4) begin
          addr_d  = AW'(mrem);
          state_d = ST_U0;
        end
      end
      ST_U0: begin
        mem_re  = 1'b1;
        state_d = ST_U1;
      end
      ST_U1: begin
        acc_d   = psh;
        state_d = ST_U2;
      end
      ST_U2: begin
        sat_r   = sat32(52'(acc_q) + ((decay_q != '0) ? 52'(psh) : 52'sd0));
        g_d     = sat_r[31:0];
        flag_d  = flag_q | sat_r[32];
        state_d = ST_U3;
      end
      ST_U3: begin
        if (cfg_i.mom != '0) begin
          sat_r     = sat32(52'(psh) + 52'(g_q));
          term_d    = sat_r[31:0];
          vout_d    = sat_r[31:0];
          flag_d    = flag_q | sat_r[32];
          mem_we    = 1'b1;
          mem_wdata = sat_r[31:0];
        end else begin
          term_d = g_q;
        end
        state_d = ST_U4;
      end
      ST_U4: state_d = ST_U5;
      ST_U5: begin
        sat_r   = sat32(52'(op_q.weight_in) - 52'(psh));
        wout_d  = sat_r[31:0];
        flag_d  = flag_q | sat_r[32];
        state_d = ST_OUT;
      end
      ST_N0: state_d = ST_N1;
      ST_N1: begin
        tot = {1'b0, sum_q} + {1'b0, prod_q[63:0]};
        if (tot[64]) begin
          nsum   = '1;
          flag_d = 1'b1;
        end else begin
          nsum = tot[63:0];
        end
        if (!op_q.norm_last) begin
          sum_d   = nsum;
          state_d = ST_OUT;
        end else begin
          sum_d = '0;
          if ((cfg_i.clip != '0) && (nsum != '0)) begin
            rn_d    = nsum;
            root_d  = '0;
            k_d     = 5'd31;
            state_d = ST_SQRT;
          end else begin
            scale_d = Q_ONE;
            state_d = ST_OUT;
          end
        end
      end
      ST_SQRT: begin
        if (rn_q >= tsum) begin
          rn_d   = rn_q - tsum;
          root_d = (root_q >> 1) + bitv;
        end else begin
          root_d = root_q >> 1;
        end
        k_d = k_q - 5'd1;
        if (k_q == 5'd0) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (root_q > {33'b0, cfg_i.clip}) begin
          div_req.start    = 1'b1;
          div_req.dividend = {cfg_i.clip, 16'b0};
          div_req.divisor  = root_q[31:0];
          state_d          = ST_DIV;
        end else begin
          scale_d = Q_ONE;
          state_d = ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          scale_d = div_rsp.quotient[16:0];
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.weight_out   = wout_q;
          out_d.velocity_out = vout_q;
          out_d.clip_scale   = scale_q;
          out_d.saturated    = flag_q;
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      sum_q       <= '0;
      scale_q     <= Q_ONE;
      rset_q      <= '0;
      dset_q      <= '0;
      rsnap_q     <= '0;
      dsnap_q     <= '0;
      ron_q       <= 1'b0;
      don_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      sum_q       <= sum_d;
      scale_q     <= scale_d;
      rset_q      <= rset_d;
      dset_q      <= dset_d;
      rsnap_q     <= rsnap_d;
      dsnap_q     <= dsnap_d;
      ron_q       <= ron_d;
      don_q       <= don_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold working payload
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    addr_q  <= addr_d;
    rate_q  <= rate_d;
    decay_q <= decay_d;
    acc_q   <= acc_d;
    g_q     <= g_d;
    term_q  <= term_d;
    wout_q  <= wout_d;
    vout_q  <= vout_d;
    flag_q  <= flag_d;
    rn_q    <= rn_d;
    root_q  <= root_d;
    k_q     <= k_d;
    out_q   <= out_d;
  end

  // Write group tables on overrides
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      if (q_op_i.override_kind == KIND_RATE) begin
        gr_q[qidx] <= q_op_i.override_value;
      end else begin
        gd_q[qidx] <= q_op_i.override_value;
      end
    end
  end

  // Velocity memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      vmem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      vrd_q <= vmem[addr_q];
    end
  end

`ifndef SYNTHESIS
  a_scale_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scale_q <= Q_ONE)
    else $error("clip scale above 1.0");
  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !pop)
    else $error("queue popped during memory clear");
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");
  a_gidx_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) && (op_q.op == OP_OVERRIDE) |->
      (32'(op_q.group_index) < GROUP_COUNT) && (gidx == GW'(op_q.group_index)))
    else $error("override executed for missing group");
`endif

endmodule

// ===== sv/sgd_momentum_update.sv =====
// SGD momentum update engine: configuration registers, front queue, back end.
// Update: queued on accept, then run through MOD (when ELEM_COUNT needs an address
// wrap), U0 to U5 and OUT; the back end takes a new operation only after the last is out.
// Norm item: N0, N1 and OUT; the last norm item may add a 32-step root and a divide.
// Reset: async, active low; the velocity memory is cleared entry by entry after
// reset, and input beats stall until the clear is done.
module sgd_momentum_update import smu_pkg::*; #(
  parameter int unsigned ELEM_COUNT  = ELEM_COUNT_DEF,
  parameter int unsigned GROUP_COUNT = GROUP_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rsp_t        out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg_q, cfg_d;
  logic       q_valid;
  op_t        q_op;
  back_stat_t stat;

  assign pready = 1'b1;

  // Write configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_LR:    cfg_d.lr    = pwdata[30:0];
        REG_MOM:   cfg_d.mom   = pwdata[30:0];
        REG_DECAY: cfg_d.decay = pwdata[30:0];
        REG_CLIP:  cfg_d.clip  = pwdata[30:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lr    <= LR_RESET;
      cfg_q.mom   <= '0;
      cfg_q.decay <= '0;
      cfg_q.clip  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back registers
  always_comb begin
    unique case (paddr[3:2])
      REG_LR:    prdata = {1'b0, cfg_q.lr};
      REG_MOM:   prdata = {1'b0, cfg_q.mom};
      REG_DECAY: prdata = {1'b0, cfg_q.decay};
      REG_CLIP:  prdata = {1'b0, cfg_q.clip};
      default:   prdata = '0;
    endcase
  end

  smu_front #(
    .GROUP_COUNT (GROUP_COUNT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_op_o     (q_op),
    .stat_i     (stat)
  );

  smu_back #(
    .ELEM_COUNT  (ELEM_COUNT),
    .GROUP_COUNT (GROUP_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_op_i      (q_op),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
